// ===== rtl/fflra_pkg.sv =====
// shared types and constants for the free-list room allocator
// no dependencies; used by every module of the block
`default_nettype none

package fflra_pkg;

    localparam int CUSTOMERS_DEF = 256;
    localparam int ROOMS_DEF     = 256;

    // fixed field widths of the stream beats
    localparam int ID_W     = 8;
    localparam int ROOM_W   = 8;
    localparam int OPENED_W = 9;
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 24;

    localparam logic REQ_ARRIVE = 1'b0;
    localparam logic REQ_DEPART = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_ABSENT  = 2'd2,
        ST_PRESENT = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE = 2'b01,
        FSM_EXEC = 2'b10
    } fsm_t;

    // free queue control from the sequencer
    typedef struct packed {
        logic rd;
        logic pop;
        logic push;
    } qctl_t;

    // customer table control from the sequencer
    typedef struct packed {
        logic rd;
        logic wr;
        logic wr_present;
    } tctl_t;

endpackage

`default_nettype wire

// ===== rtl/fflra_cust_table.sv =====
// customer table: one memory entry per customer holding present bit and room
// clears every entry after reset; uses fflra_pkg
`default_nettype none

module fflra_cust_table #(
    parameter int CUSTOMERS = fflra_pkg::CUSTOMERS_DEF,
    parameter int RW        = 8
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire fflra_pkg::tctl_t              ctl,
    input  wire logic [$clog2(CUSTOMERS)-1:0]  rd_addr,
    input  wire logic [$clog2(CUSTOMERS)-1:0]  wr_addr,
    input  wire logic [RW-1:0]                 wr_room,
    output logic                               rd_present,
    output logic [RW-1:0]                      rd_room,
    output logic                               busy
);

    localparam int CW = $clog2(CUSTOMERS);

    logic [RW:0]   mem [CUSTOMERS];
    logic [RW:0]   rd_data_reg;
    logic          clr_reg;
    logic          clr_next;
    logic [CW-1:0] clr_addr_reg;
    logic [CW-1:0] clr_addr_next;
    logic          we;
    logic [CW-1:0] waddr;
    logic [RW:0]   wdata;

    always_comb begin
        clr_next      = clr_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_reg) begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == CW'(CUSTOMERS - 1)) begin
                clr_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            clr_reg      <= clr_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // sweep writes win; no beat is taken while sweeping
    assign we    = clr_reg || ctl.wr;
    assign waddr = clr_reg ? clr_addr_reg : wr_addr;
    assign wdata = clr_reg ? '0 : {ctl.wr_present, wr_room};

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (ctl.rd) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_present = rd_data_reg[RW];
    assign rd_room    = rd_data_reg[RW-1:0];
    assign busy       = clr_reg;

endmodule

`default_nettype wire

// ===== rtl/fflra_free_queue.sv =====
// fifo of freed room numbers in a memory with head, tail and count
// uses fflra_pkg for the control struct
`default_nettype none

module fflra_free_queue #(
    parameter int ROOMS = fflra_pkg::ROOMS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire fflra_pkg::qctl_t             ctl,
    input  wire logic [$clog2(ROOMS)-1:0]     push_room,
    output logic      [$clog2(ROOMS)-1:0]     head_room,
    output logic      [$clog2(ROOMS+1)-1:0]   count
);

    localparam int RW = $clog2(ROOMS);
    localparam int OW = $clog2(ROOMS + 1);

    logic [RW-1:0] mem [ROOMS];
    logic [RW-1:0] head_room_reg;
    logic [RW-1:0] head_reg;
    logic [RW-1:0] head_next;
    logic [RW-1:0] tail_reg;
    logic [RW-1:0] tail_next;
    logic [OW-1:0] count_reg;
    logic [OW-1:0] count_next;

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (ctl.pop) begin
            head_next = (head_reg == RW'(ROOMS - 1)) ? '0 : head_reg + 1'b1;
        end
        if (ctl.push) begin
            tail_next = (tail_reg == RW'(ROOMS - 1)) ? '0 : tail_reg + 1'b1;
        end
        priority if (ctl.push && !ctl.pop) begin
            count_next = count_reg + 1'b1;
        end else if (ctl.pop && !ctl.push) begin
            count_next = count_reg - 1'b1;
        end else begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.push) begin
            mem[tail_reg] <= push_room;
        end
        if (ctl.rd) begin
            head_room_reg <= mem[head_reg];
        end
    end

    assign head_room = head_room_reg;
    assign count     = count_reg;

endmodule

`default_nettype wire

// ===== rtl/fifo_free_list_room_allocator_core.sv =====
// top level of the free-list room allocator: event sequencer and result register
// instantiates fflra_cust_table and fflra_free_queue; uses fflra_pkg
//
// s_ channel: one event per beat. s_tuser[0] is the kind (0 arrival, 1 departure),
// s_tdata[7:0] the customer id. m_ channel: one result per event. m_tdata holds
// room [7:0] and rooms opened after the event [16:8]; m_tuser[1:0] is the status
// (ok, no room left, customer absent, customer already present).
// An accepted beat reads the customer table and the free queue head in its
// accept cycle; the decide step follows in the next cycle and, once the result
// register is free, writes both memories back and loads the result register.
// The decide step waits on the registered reads of both memories; the next beat
// is taken only once the decide step has fired and the sequencer is idle again.
// A result waiting on a stalled receiver does not block the next accept; that
// event is held in its decide step until the result register frees.
// After reset the customer table is swept clear, one entry per cycle, and
// s_tready stays low until all CUSTOMERS entries (256 by default) are clear.
`default_nettype none

module fifo_free_list_room_allocator_core #(
    parameter int CUSTOMERS = fflra_pkg::CUSTOMERS_DEF,
    parameter int ROOMS     = fflra_pkg::ROOMS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [fflra_pkg::S_DATA_W-1:0]   s_tdata,   // customer_id
    input  wire logic [0:0]                       s_tuser,   // req_type
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [fflra_pkg::M_DATA_W-1:0]   m_tdata,   // room, rooms_opened, pad
    output logic      [1:0]                       m_tuser    // status
);

    localparam int CW = $clog2(CUSTOMERS);
    localparam int RW = $clog2(ROOMS);
    localparam int OW = $clog2(ROOMS + 1);

    fflra_pkg::fsm_t    state_reg, state_next;
    fflra_pkg::tctl_t   tctl;
    fflra_pkg::qctl_t   qctl;
    fflra_pkg::status_t res_status;
    fflra_pkg::status_t out_status_reg;

    logic          s_accept;
    logic          exec_fire;
    logic          tbl_busy;
    logic [31:0]   id_wide;
    logic [CW-1:0] id_idx;
    logic          id_ok_reg;
    logic          kind_reg;
    logic [CW-1:0] cust_reg;
    logic          ent_present;
    logic [RW-1:0] ent_room;
    logic [RW-1:0] q_room;
    logic [OW-1:0] q_count;
    logic [OW-1:0] opened_reg;
    logic [OW-1:0] opened_next;
    logic [RW-1:0] res_room;
    logic          res_wr;
    logic          res_present;
    logic          res_pop;
    logic          res_push;
    logic [31:0]   room_wide;
    logic [31:0]   opened_wide;
    logic          out_valid_reg;
    logic [fflra_pkg::ROOM_W-1:0]   out_room_reg;
    logic [fflra_pkg::OPENED_W-1:0] out_opened_reg;

    assign s_tready  = (state_reg == fflra_pkg::FSM_IDLE) && !tbl_busy;
    assign s_accept  = s_tvalid && s_tready;
    assign exec_fire = (state_reg == fflra_pkg::FSM_EXEC) && (!out_valid_reg || m_tready);

    assign id_wide = 32'(s_tdata[fflra_pkg::ID_W-1:0]);
    assign id_idx  = id_wide[CW-1:0];

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            fflra_pkg::FSM_IDLE: if (s_accept) state_next = fflra_pkg::FSM_EXEC;
            fflra_pkg::FSM_EXEC: if (exec_fire) state_next = fflra_pkg::FSM_IDLE;
            default:             state_next = fflra_pkg::FSM_IDLE;
        endcase
    end

    // decide the event from the table entry and queue head read at accept
    always_comb begin
        res_room    = '0;
        res_status  = fflra_pkg::ST_ABSENT;
        res_wr      = 1'b0;
        res_present = 1'b0;
        res_pop     = 1'b0;
        res_push    = 1'b0;
        opened_next = opened_reg;
        if (id_ok_reg) begin
            if (kind_reg == fflra_pkg::REQ_ARRIVE) begin
                priority if (ent_present) begin
                    res_room   = ent_room;
                    res_status = fflra_pkg::ST_PRESENT;
                end else if (q_count != '0) begin
                    res_room    = q_room;
                    res_status  = fflra_pkg::ST_OK;
                    res_pop     = 1'b1;
                    res_wr      = 1'b1;
                    res_present = 1'b1;
                end else if (opened_reg < OW'(ROOMS)) begin
                    res_room    = opened_reg[RW-1:0];
                    res_status  = fflra_pkg::ST_OK;
                    opened_next = opened_reg + 1'b1;
                    res_wr      = 1'b1;
                    res_present = 1'b1;
                end else begin
                    res_status = fflra_pkg::ST_FULL;
                end
            end else if (ent_present) begin
                res_room   = ent_room;
                res_status = fflra_pkg::ST_OK;
                res_wr     = 1'b1;
                res_push   = (q_count != OW'(ROOMS));
            end
        end
    end

    assign tctl.rd         = s_accept;
    assign tctl.wr         = exec_fire && res_wr;
    assign tctl.wr_present = res_present;
    assign qctl.rd         = s_accept;
    assign qctl.pop        = exec_fire && res_pop;
    assign qctl.push       = exec_fire && res_push;

    assign room_wide   = 32'(res_room);
    assign opened_wide = 32'(opened_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= fflra_pkg::FSM_IDLE;
            opened_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (exec_fire) begin
                opened_reg    <= opened_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            id_ok_reg <= (id_wide < 32'(CUSTOMERS));
            kind_reg  <= s_tuser[0];
            cust_reg  <= id_idx;
        end
        if (exec_fire) begin
            out_room_reg   <= room_wide[fflra_pkg::ROOM_W-1:0];
            out_opened_reg <= opened_wide[fflra_pkg::OPENED_W-1:0];
            out_status_reg <= res_status;
        end
    end

    fflra_cust_table #(
        .CUSTOMERS (CUSTOMERS),
        .RW        (RW)
    ) u_table (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (tctl),
        .rd_addr    (id_idx),
        .wr_addr    (cust_reg),
        .wr_room    (res_room),
        .rd_present (ent_present),
        .rd_room    (ent_room),
        .busy       (tbl_busy)
    );

    fflra_free_queue #(
        .ROOMS (ROOMS)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (qctl),
        .push_room (res_room),
        .head_room (q_room),
        .count     (q_count)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(fflra_pkg::M_DATA_W - fflra_pkg::OPENED_W - fflra_pkg::ROOM_W){1'b0}},
                       out_opened_reg, out_room_reg};
    assign m_tuser  = out_status_reg;

endmodule

`default_nettype wire

// ===== rtl/fflra_checker.sv =====
// port-level checks for the free-list room allocator, bound to the top level
// uses fflra_pkg for field widths and status codes
`default_nettype none

module fflra_checker #(
    parameter int ROOMS = fflra_pkg::ROOMS_DEF
) (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             s_tvalid,
    input wire logic                             s_tready,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [fflra_pkg::M_DATA_W-1:0]   m_tdata,
    input wire logic [1:0]                       m_tuser
);

    // a stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // one event in flight: no accept right after an accept
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted on consecutive cycles");

    // an accepted event is followed by an offered result beat
    a_res: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> ##2 m_tvalid)
        else $error("no result after accepted event");

    // failed allocation or absent customer reports room zero
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == fflra_pkg::ST_FULL || m_tuser == fflra_pkg::ST_ABSENT)
        |-> m_tdata[fflra_pkg::ROOM_W-1:0] == '0)
        else $error("nonzero room on failed event");

    // rooms opened never exceeds the room count, pad bits zero
    a_open: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (32'(m_tdata[16:8]) <= 32'(ROOMS)) && (m_tdata[23:17] == '0))
        else $error("rooms opened out of range");

endmodule

bind fifo_free_list_room_allocator_core fflra_checker #(
    .ROOMS (ROOMS)
) u_fflra_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
